@@ rtl/core/gcs_pkg.sv @@
// Shared types and constants for the gray-level contrast stretch block.
// Used by gcs_ctrl, gcs_dp and gray_contrast_stretch; depends on nothing.
package gcs_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_W     = 2 * PIX_W;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_ZERO   = 8'd0;

  // Operation codes carried by the input item.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic measure;  // fold the input pixel into the running min and max
    logic load;     // latch the scaled numerator and divisor of a map item
    logic step;     // one restoring division step
    logic emit;     // copy the finished result into the output register
  } gcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic degenerate;  // current max is not above current min
  } gcs_sts_t;

endpackage

@@ rtl/core/gray_contrast_stretch.sv @@
// Measure items update min and max at accept and give no result. A map item
// raises out_valid after its load, 8 divider steps and hand-off; a degenerate
// range skips the divider. No new item is taken until a map item's result has
// been handed off; measure items are taken every cycle while no map item is in
// progress. Reset (rst_n low, synchronous) sets min to 255, max to 0 and
// empties the output register.
module gray_contrast_stretch (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [gcs_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gcs_pkg::PIX_W-1:0] out_stretched_pixel,
  output logic                      out_degenerate
);
  import gcs_pkg::*;

  // The controller sequences each item; the datapath holds the running
  // minimum and maximum, the divider registers and the output payload.
  gcs_cmd_t cmd;
  gcs_sts_t sts;

  // The controller accepts an item only in its idle state. A finished result
  // sits in the output register, so a new item can be taken while the
  // downstream side is still stalling on the previous result.
  gcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid)
  );

  // The datapath clamps the pixel into the measured range, subtracts the minimum,
  // scales by 255 and divides by the range width, one quotient bit per cycle.
  gcs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_pixel            (in_pixel),
    .in_frame_start      (in_frame_start),
    .sts                 (sts),
    .out_stretched_pixel (out_stretched_pixel),
    .out_degenerate      (out_degenerate)
  );

endmodule

@@ rtl/core/gcs_dp.sv @@
// Datapath of the contrast stretch: min/max registers, clamp and scale,
// restoring divider and output payload register. Depends on gcs_pkg.
module gcs_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gcs_pkg::gcs_cmd_t        cmd,
  input  logic [gcs_pkg::PIX_W-1:0] in_pixel,
  input  logic                     in_frame_start,
  output gcs_pkg::gcs_sts_t        sts,
  output logic [gcs_pkg::PIX_W-1:0] out_stretched_pixel,
  output logic                     out_degenerate
);
  import gcs_pkg::*;

  logic [PIX_W-1:0] low_r, low_nxt;
  logic [PIX_W-1:0] high_r, high_nxt;
  logic [PIX_W-1:0] rem_r, rem_nxt;
  logic [PIX_W-1:0] quo_r, quo_nxt;
  logic [PIX_W-1:0] den_r, den_nxt;
  logic             deg_r, deg_nxt;
  logic [PIX_W-1:0] res_r;
  logic             res_deg_r;

  logic             degen;
  logic [PIX_W-1:0] clamped;
  logic [PIX_W-1:0] diff;
  logic [NUM_W-1:0] num;
  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   trial_sub;

  assign degen = (high_r <= low_r);
  assign sts.degenerate = degen;

  always_comb begin
    if (in_pixel < low_r) begin
      clamped = low_r;
    end else if (in_pixel > high_r) begin
      clamped = high_r;
    end else begin
      clamped = in_pixel;
    end
    diff = clamped - low_r;
    // diff * 255 written as diff * 256 - diff.
    num  = {diff, PIX_ZERO} - {PIX_ZERO, diff};
  end

  assign trial     = {rem_r, quo_r[PIX_W-1]};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    deg_nxt  = deg_r;
    if (cmd.measure) begin
      if (in_frame_start) begin
        low_nxt  = in_pixel;
        high_nxt = in_pixel;
      end else begin
        if (in_pixel < low_r) low_nxt = in_pixel;
        if (in_pixel > high_r) high_nxt = in_pixel;
      end
    end
    if (cmd.load) begin
      // The quotient fits in eight bits, so the upper dividend byte is
      // already below the divisor and seeds the remainder.
      deg_nxt = degen;
      den_nxt = high_r - low_r;
      if (degen) begin
        rem_nxt = PIX_ZERO;
        quo_nxt = PIX_ZERO;
      end else begin
        rem_nxt = num[NUM_W-1:PIX_W];
        quo_nxt = num[PIX_W-1:0];
      end
    end
    if (cmd.step) begin
      if (!trial_sub[PIX_W]) begin
        rem_nxt = trial_sub[PIX_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PIX_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= FULL_SCALE;
      high_r <= PIX_ZERO;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    deg_r <= deg_nxt;
    if (cmd.emit) begin
      res_r     <= quo_r;
      res_deg_r <= deg_r;
    end
  end

  assign out_stretched_pixel = res_r;
  assign out_degenerate      = res_deg_r;

endmodule

@@ rtl/core/gcs_ctrl.sv @@
// Controller of the contrast stretch: sequences accept, division steps and
// result hand-off, and owns the output valid. Depends on gcs_pkg.
module gcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  input  logic              out_stall,
  input  gcs_pkg::gcs_sts_t sts,
  output gcs_pkg::gcs_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import gcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;
  logic             slot_free;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_MEASURE) begin
            cmd.measure = 1'b1;
          end else begin
            cmd.load = 1'b1;
            cnt_nxt  = CNT_ZERO;
            state_nxt = sts.degenerate ? S_FIN : S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("gcs_ctrl: more than one datapath command at once");

  a_emit_slot : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("gcs_ctrl: result emitted over an untaken result");

  a_map_to_div : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_MAP && !sts.degenerate) |=> state_r == S_DIV)
    else $error("gcs_ctrl: map item did not start the division");

  a_div_runs : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != CNT_LAST) |=> (state_r == S_DIV && cmd.step))
    else $error("gcs_ctrl: division left before its last step");

endmodule
